// File: rtl/sparkle_permutation_assert.svh
// Assertion macros for the permutation block
`ifndef SPARKLE_PERMUTATION_ASSERT_SVH
`define SPARKLE_PERMUTATION_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define SPK_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define SPK_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/spk_pkg.sv
// -----------------------------------------------------------------------------
// spk_pkg
// Shared constants, types and functions of the permutation block.
// -----------------------------------------------------------------------------
package spk_pkg;
  localparam int MAX_BRANCH_COUNT = 8;
  localparam int WORD_DEPTH = 2 * MAX_BRANCH_COUNT;
  localparam int IDX_W = $clog2(WORD_DEPTH);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_INV  = 2'd2;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic [3:0]  step_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_index;
    logic [31:0] out_value;
    logic        last;
  } out_item_t;

  function automatic word_t rcon(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'hB7E15162;
      3'd1: r = 32'hBF715880;
      3'd2: r = 32'h38B4DA56;
      3'd3: r = 32'h324E7738;
      3'd4: r = 32'hBB1185EB;
      3'd5: r = 32'h4F7C7B57;
      3'd6: r = 32'hCFBFA1C8;
      default: r = 32'hC2B3293D;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t v, input int r);
    return (v >> r) | (v << (32 - r));
  endfunction

  function automatic word_t ell(input word_t v);
    return rotr(v ^ (v << 16), 16);
  endfunction

  // One Alzette round: a is the rotation on y into x, b on x into y
  function automatic logic [63:0] arx_fwd(input word_t x, input word_t y, input word_t c,
                                          input int a, input int b);
    word_t nx, ny;
    nx = x + ((a == 0) ? y : rotr(y, a));
    ny = y ^ rotr(nx, b);
    nx = nx ^ c;
    return {nx, ny};
  endfunction

  function automatic logic [63:0] arx_inv(input word_t x, input word_t y, input word_t c,
                                          input int a, input int b);
    word_t nx, ny;
    nx = x ^ c;
    ny = y ^ rotr(nx, b);
    nx = nx - ((a == 0) ? ny : rotr(ny, a));
    return {nx, ny};
  endfunction
endpackage

// File: rtl/spk_stream_if.sv
// -----------------------------------------------------------------------------
// spk_stream_if
// Valid/ready channel carrying one payload.
// -----------------------------------------------------------------------------
interface spk_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/spk_ram.sv
// -----------------------------------------------------------------------------
// spk_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module spk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/spk_core.sv
// -----------------------------------------------------------------------------
// spk_core
// Sequencer around the word RAM: clears it after reset, applies loads,
// runs steps on work registers, writes back and streams the state out.
// -----------------------------------------------------------------------------
module spk_core import spk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] branch_count,
  spk_stream_if.sink   in_ch,
  spk_stream_if.source out_ch
);
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;   // read all words into work regs
  localparam logic [3:0] S_ADD  = 4'd3;   // constants into words 1 and 3
  localparam logic [3:0] S_BOX  = 4'd4;   // one Alzette round per cycle
  localparam logic [3:0] S_LIN  = 4'd5;   // linear layer
  localparam logic [3:0] S_WR   = 4'd6;   // write back one word per cycle
  localparam logic [3:0] S_OUT  = 4'd7;   // stream words out
  localparam logic [3:0] S_IBOX = 4'd8;   // inverse rounds
  localparam logic [3:0] S_IADD = 4'd9;

  logic [3:0] state;
  logic [IDX_W:0] cnt;        // word counter
  logic [3:0] steps, step_i;  // remaining and current step
  logic [1:0] mode;
  logic [3:0] nb;             // active branches
  word_t w [WORD_DEPTH];      // work registers, one per word
  logic [2:0] br;             // branch under the box
  logic [1:0] rnd;
  logic rd_pend;
  logic [IDX_W-1:0] rd_idx;

  logic ram_we;
  logic [IDX_W-1:0] ram_wa, ram_ra;
  word_t ram_wd, ram_rd;

  spk_ram #(.WIDTH(32), .DEPTH(WORD_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  // Active branch count: low bit dropped, clamped to 4..MAX
  logic [3:0] nb_cfg;
  always_comb begin
    nb_cfg = branch_count & 4'hE;
    if (nb_cfg < 4'd4) nb_cfg = 4'd4;
    if (nb_cfg > 4'(MAX_BRANCH_COUNT & 14)) nb_cfg = 4'(MAX_BRANCH_COUNT & 14);
  end

  // Output register; frees when taken
  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // RAM port control
  always_comb begin
    ram_we = 1'b0;
    ram_wa = cnt[IDX_W-1:0];
    ram_wd = w[cnt[IDX_W-1:0]];
    ram_ra = cnt[IDX_W-1:0];
    if (state == S_CLR) begin
      ram_we = 1'b1;
      ram_wd = '0;
    end else if (state == S_IDLE) begin
      ram_we = in_ch.valid && in_ch.data.mode == MODE_LOAD;
      ram_wa = in_ch.data.word_index;
      ram_wd = in_ch.data.word_value;
    end else if (state == S_WR) begin
      ram_we = 1'b1;
    end
  end

  // Box round operands
  logic [63:0] box_f, box_i;
  word_t bc;
  always_comb begin
    bc = rcon(br);
    unique case (rnd)
      2'd0: box_f = arx_fwd(w[{br, 1'b0}], w[{br, 1'b1}], bc, 31, 24);
      2'd1: box_f = arx_fwd(w[{br, 1'b0}], w[{br, 1'b1}], bc, 17, 17);
      2'd2: box_f = arx_fwd(w[{br, 1'b0}], w[{br, 1'b1}], bc, 0, 31);
      default: box_f = arx_fwd(w[{br, 1'b0}], w[{br, 1'b1}], bc, 24, 16);
    endcase
    unique case (rnd)
      2'd0: box_i = arx_inv(w[{br, 1'b0}], w[{br, 1'b1}], bc, 24, 16);
      2'd1: box_i = arx_inv(w[{br, 1'b0}], w[{br, 1'b1}], bc, 0, 31);
      2'd2: box_i = arx_inv(w[{br, 1'b0}], w[{br, 1'b1}], bc, 17, 17);
      default: box_i = arx_inv(w[{br, 1'b0}], w[{br, 1'b1}], bc, 31, 24);
    endcase
  end

  // Linear layer, forward and inverse, over the work registers
  word_t lf [WORD_DEPTH];
  word_t li [WORD_DEPTH];
  always_comb begin
    word_t tx, ty;
    int h;
    h = int'(nb);
    lf = w;
    tx = '0; ty = '0;
    for (int j = 0; j < MAX_BRANCH_COUNT; j += 2) begin
      if (j < h) begin
        tx ^= w[j]; ty ^= w[j+1];
      end
    end
    tx = ell(tx); ty = ell(ty);
    for (int j = 2; j < MAX_BRANCH_COUNT; j += 2) begin
      if (j < h) begin
        lf[j-2] = w[j+h] ^ w[j] ^ ty;
        lf[j-1] = w[j+h+1] ^ w[j+1] ^ tx;
        lf[j+h] = w[j];
        lf[j+h+1] = w[j+1];
      end
    end
    lf[h-2] = w[h] ^ ty ^ w[0];
    lf[h-1] = w[h+1] ^ tx ^ w[1];
    lf[h] = w[0];
    lf[h+1] = w[1];
    // inverse: rotate halves back, then fold the mixing term in
    li = w;
    for (int j = 2; j < MAX_BRANCH_COUNT; j += 2) begin
      if (j < h) begin
        li[j] = w[j+h];
        li[j+1] = w[j+h+1];
        li[j+h] = w[j-2];
        li[j+h+1] = w[j-1];
      end
    end
    li[0] = w[h]; li[1] = w[h+1];
    li[h] = w[h-2]; li[h+1] = w[h-1];
    tx = '0; ty = '0;
    for (int j = 0; j < MAX_BRANCH_COUNT; j += 2) begin
      if (j < h) begin
        tx ^= li[j]; ty ^= li[j+1];
      end
    end
    tx = ell(tx); ty = ell(ty);
    for (int j = 0; j < MAX_BRANCH_COUNT; j += 2) begin
      if (j < h) begin
        li[j+h] = li[j+h] ^ ty ^ li[j];
        li[j+h+1] = li[j+h+1] ^ tx ^ li[j+1];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      out_ch.valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      // outside the emit phase a taken word simply drops
      if (state != S_OUT && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (IDX_W+1)'(WORD_DEPTH-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_ch.valid && (in_ch.data.mode == MODE_FWD || in_ch.data.mode == MODE_INV))
          begin
            mode <= in_ch.data.mode;
            steps <= in_ch.data.step_count;
            step_i <= (in_ch.data.mode == MODE_INV) ? in_ch.data.step_count - 1'b1 : '0;
            nb <= nb_cfg;
            state <= S_RD;
          end
        end
        S_RD: begin
          // issue reads for cnt, capture the word of the previous cycle
          if (rd_pend) w[rd_idx] <= ram_rd;
          if (cnt < (IDX_W+1)'(WORD_DEPTH)) begin
            rd_pend <= 1'b1;
            rd_idx <= cnt[IDX_W-1:0];
            cnt <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            br <= '0; rnd <= '0;
            cnt <= '0;
            if (steps == '0) state <= S_OUT;
            else if (mode == MODE_FWD) state <= S_ADD;
            else state <= S_LIN;
          end
        end
        S_ADD: begin
          w[1] <= w[1] ^ rcon(step_i[2:0]);
          w[3] <= w[3] ^ 32'(step_i);
          state <= S_BOX;
        end
        S_BOX, S_IBOX: begin
          w[{br, 1'b0}] <= (state == S_BOX) ? box_f[63:32] : box_i[63:32];
          w[{br, 1'b1}] <= (state == S_BOX) ? box_f[31:0] : box_i[31:0];
          rnd <= rnd + 1'b1;
          if (rnd == 2'd3) begin
            if ({1'b0, br} == nb - 1'b1) begin
              br <= '0;
              state <= (state == S_BOX) ? S_LIN : S_IADD;
            end else begin
              br <= br + 1'b1;
            end
          end
        end
        S_LIN: begin
          if (mode == MODE_FWD) begin
            w <= lf;
            step_i <= step_i + 1'b1;
            steps <= steps - 1'b1;
            state <= (steps == 4'd1) ? S_WR : S_ADD;
          end else begin
            w <= li;
            state <= S_IBOX;
          end
        end
        S_IADD: begin
          w[1] <= w[1] ^ rcon(step_i[2:0]);
          w[3] <= w[3] ^ 32'(step_i);
          step_i <= step_i - 1'b1;
          steps <= steps - 1'b1;
          state <= (steps == 4'd1) ? S_WR : S_LIN;
        end
        S_WR: begin
          if (cnt == (IDX_W+1)'(WORD_DEPTH-1)) begin
            cnt <= '0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.data.out_index <= cnt[3:0];
            out_ch.data.out_value <= w[cnt[IDX_W-1:0]];
            out_ch.data.last <= (cnt == (IDX_W+1)'(WORD_DEPTH-1));
            cnt <= cnt + 1'b1;
            if (cnt == (IDX_W+1)'(WORD_DEPTH-1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/sparkle_permutation.sv
// -----------------------------------------------------------------------------
// sparkle_permutation
// SPARKLE permutation over a 16-word state held in RAM.
// -----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   mode, word_index, word_value, step_count
//  out_ch    out  out_index, out_value, last
//  cfg       in   branch_count (cfg_we / cfg_data)
// A load is written straight into the RAM. A run reads the state, then steps it with
// one Alzette round per cycle, writes the state back and emits it word by word.
// After reset a clearing pass zeroes the RAM; no item is taken then.
// Output stalls hold the sequencer in the emit phase.
module sparkle_permutation import spk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  spk_stream_if.sink   in_ch,
  spk_stream_if.source out_ch
);
  logic [3:0] branch_count;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) branch_count <= 4'd8;
    else if (cfg_we) branch_count <= cfg_data;
  end

  spk_core u_core (
    .clk(clk), .rst(rst), .branch_count(branch_count),
    .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

// File: rtl/spk_checker.sv
// -----------------------------------------------------------------------------
// spk_checker
// Port-level checks of the permutation block.
// -----------------------------------------------------------------------------
`include "sparkle_permutation_assert.svh"
module spk_checker import spk_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  // No new transaction is taken while a run is still emitting words
  `SPK_ASSERT_IMP(a_no_in_while_out, clk, rst, out_valid && !out_data.last, !in_ready)
  // Stalled result holds
  `SPK_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // Last word sits at the top index
  `SPK_ASSERT_IMP(a_last, clk, rst, out_valid && out_data.last, out_data.out_index == 4'(WORD_DEPTH-1))
endmodule

bind sparkle_permutation spk_checker u_chk (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

// File: verif/sparkle_permutation_tb.sv
// -----------------------------------------------------------------------------
// sparkle_permutation_tb
// Self-checking bench: loads, forward and inverse runs, every active branch count,
// random sender and receiver idling, and a behavioral predictor of the state.
// -----------------------------------------------------------------------------
module sparkle_permutation_tb;
  import spk_pkg::*;

  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_data;

  spk_stream_if #(.T(in_item_t))  in_ch ();
  spk_stream_if #(.T(out_item_t)) out_ch ();

  sparkle_permutation u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor state
  word_t     state_words [WORD_DEPTH];
  logic [3:0] nb_reg;
  out_item_t word_queue [$];
  int        err_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Round constant table
  function automatic word_t step_const(input int i);
    case (i & 7)
      0: return 32'hB7E15162;
      1: return 32'hBF715880;
      2: return 32'h38B4DA56;
      3: return 32'h324E7738;
      4: return 32'hBB1185EB;
      5: return 32'h4F7C7B57;
      6: return 32'hCFBFA1C8;
      default: return 32'hC2B3293D;
    endcase
  endfunction

  function automatic word_t ror32(input word_t v, input int r);
    return (v >> r) | (v << (32 - r));
  endfunction

  function automatic word_t lin_ell(input word_t v);
    return ror32(v ^ (v << 16), 16);
  endfunction

  function automatic int branches_in_use();
    int n;
    n = nb_reg & 4'hE;
    if (n < 4) n = 4;
    if (n > MAX_BRANCH_COUNT) n = MAX_BRANCH_COUNT;
    return n;
  endfunction

  // Alzette forward on branch k
  task automatic alz_fwd(input int k, input word_t c);
    word_t x, y;
    x = state_words[2*k]; y = state_words[2*k+1];
    x = x + ror32(y, 31); y = y ^ ror32(x, 24); x = x ^ c;
    x = x + ror32(y, 17); y = y ^ ror32(x, 17); x = x ^ c;
    x = x + y;            y = y ^ ror32(x, 31); x = x ^ c;
    x = x + ror32(y, 24); y = y ^ ror32(x, 16); x = x ^ c;
    state_words[2*k] = x; state_words[2*k+1] = y;
  endtask

  task automatic alz_inv(input int k, input word_t c);
    word_t x, y;
    x = state_words[2*k]; y = state_words[2*k+1];
    x = x ^ c; y = y ^ ror32(x, 16); x = x - ror32(y, 24);
    x = x ^ c; y = y ^ ror32(x, 31); x = x - y;
    x = x ^ c; y = y ^ ror32(x, 17); x = x - ror32(y, 17);
    x = x ^ c; y = y ^ ror32(x, 24); x = x - ror32(y, 31);
    state_words[2*k] = x; state_words[2*k+1] = y;
  endtask

  task automatic permute_fwd(input int nb, input int steps);
    word_t x0, y0, tx, ty;
    int h;
    h = nb;
    for (int i = 0; i < steps; i++) begin
      state_words[1] ^= step_const(i);
      state_words[3] ^= word_t'(i);
      for (int j = 0; j < nb; j++) alz_fwd(j, step_const(j));
      x0 = state_words[0]; y0 = state_words[1];
      tx = x0; ty = y0;
      for (int j = 2; j < h; j += 2) begin
        tx ^= state_words[j]; ty ^= state_words[j+1];
      end
      tx = lin_ell(tx); ty = lin_ell(ty);
      for (int j = 2; j < h; j += 2) begin
        state_words[j-2] = state_words[j+h] ^ state_words[j] ^ ty;
        state_words[j-1] = state_words[j+h+1] ^ state_words[j+1] ^ tx;
        state_words[j+h] = state_words[j];
        state_words[j+h+1] = state_words[j+1];
      end
      state_words[h-2] = state_words[h] ^ ty ^ x0;
      state_words[h-1] = state_words[h+1] ^ tx ^ y0;
      state_words[h] = x0;
      state_words[h+1] = y0;
    end
  endtask

  task automatic permute_inv(input int nb, input int steps);
    word_t xl, yl, tx, ty;
    int h;
    h = nb;
    for (int i = steps - 1; i >= 0; i--) begin
      xl = state_words[h-2]; yl = state_words[h-1];
      tx = '0; ty = '0;
      for (int j = h - 2; j > 0; j -= 2) begin
        state_words[j] = state_words[j+h];
        state_words[j+1] = state_words[j+h+1];
        state_words[j+h] = state_words[j-2];
        state_words[j+h+1] = state_words[j-1];
        tx ^= state_words[j]; ty ^= state_words[j+1];
      end
      state_words[0] = state_words[h]; state_words[1] = state_words[h+1];
      tx ^= state_words[0]; ty ^= state_words[1];
      state_words[h] = xl; state_words[h+1] = yl;
      tx = lin_ell(tx); ty = lin_ell(ty);
      for (int j = 0; j < h; j += 2) begin
        state_words[j+h] ^= ty ^ state_words[j];
        state_words[j+h+1] ^= tx ^ state_words[j+1];
      end
      for (int j = 0; j < nb; j++) alz_inv(j, step_const(j));
      state_words[1] ^= step_const(i);
      state_words[3] ^= word_t'(i);
    end
  endtask

  // Update the predicted state for one transaction and queue the words of a run
  task automatic predict_words(input in_item_t it);
    out_item_t o;
    if (it.mode == MODE_LOAD) begin
      state_words[it.word_index] = it.word_value;
      return;
    end
    if (it.mode == MODE_BAD) return;
    if (it.mode == MODE_FWD) permute_fwd(branches_in_use(), it.step_count);
    else permute_inv(branches_in_use(), it.step_count);
    for (int w = 0; w < WORD_DEPTH; w++) begin
      o.out_index = w[3:0];
      o.out_value = state_words[w];
      o.last = (w == WORD_DEPTH - 1);
      word_queue.push_back(o);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // Send one transaction, with sender idling; valid stays up after the
  // accepting edge until the next send or a pause lowers it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_words(it);
  endtask

  task automatic send_load(input int idx, input word_t v);
    in_item_t it;
    it = '0;
    it.mode = MODE_LOAD; it.word_index = idx[3:0]; it.word_value = v;
    it.step_count = 4'($urandom);
    send_item(it);
  endtask

  task automatic send_run(input logic [1:0] m, input int steps);
    in_item_t it;
    it.mode = m; it.step_count = steps[3:0];
    it.word_index = 4'($urandom); it.word_value = $urandom;
    send_item(it);
  endtask

  // Wait until idle, then write the branch count
  task automatic set_branches(input logic [3:0] v);
    in_ch.valid <= 1'b0;
    while (word_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    nb_reg = v;
  endtask

  task automatic test_directed();
    send_run(MODE_FWD, 0);
    for (int w = 0; w < WORD_DEPTH; w++)
      send_load(w, (w == 0) ? 32'hFFFF_FFFF : (w == 1) ? 32'h0 : $urandom);
    send_run(MODE_FWD, 15);
    send_run(MODE_INV, 15);
    send_run(MODE_BAD, 5);
    send_run(MODE_INV, 1);
    send_run(MODE_FWD, 1);
  endtask

  task automatic test_branch_counts();
    logic [3:0] vals [7];
    vals = '{4'd4, 4'd6, 4'd5, 4'd7, 4'd0, 4'd15, 4'd8};
    foreach (vals[i]) begin
      set_branches(vals[i]);
      send_run(MODE_FWD, $urandom_range(1, 15));
      send_run(MODE_INV, $urandom_range(0, 15));
    end
  endtask

  // Random items, mostly loads and runs, some invalid-mode noise
  task automatic test_random(input int n_items);
    int r;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 50) set_branches(4'($urandom));
      if (k == 120) begin
        in_ch.valid <= 1'b0;
        while (word_queue.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 60) send_load($urandom_range(15), $urandom);
      else if (r < 78) send_run(MODE_FWD, (r < 75) ? $urandom_range(0, 4)
                                               : $urandom_range(0, 15));
      else if (r < 96) send_run(MODE_INV, (r < 93) ? $urandom_range(0, 4)
                                               : $urandom_range(0, 15));
      else send_run(MODE_BAD, $urandom_range(15));
    end
  endtask

  // Receiver: random stall, check each accepted word
  always @(posedge clk) begin
    out_item_t exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (word_queue.size() == 0) begin
          report_mismatch("unexpected word", out_ch.data.out_value, '0);
        end else begin
          exp_w = word_queue.pop_front();
          if (out_ch.data.out_index !== exp_w.out_index)
            report_mismatch("out_index", 32'(out_ch.data.out_index), 32'(exp_w.out_index));
          if (out_ch.data.out_value !== exp_w.out_value)
            report_mismatch("out_value", out_ch.data.out_value, exp_w.out_value);
          if (out_ch.data.last !== exp_w.last)
            report_mismatch("last", 32'(out_ch.data.last), 32'(exp_w.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    nb_reg = 4'd8;
    foreach (state_words[i]) state_words[i] = '0;
    send_idle_pct = 11; recv_idle_pct = 84;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_branch_counts();
    test_random(140);
    send_idle_pct = 84; recv_idle_pct = 11;
    test_random(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(140);

    in_ch.valid <= 1'b0;
    while (word_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/spk_pkg.sv
rtl/spk_stream_if.sv
rtl/spk_ram.sv
rtl/spk_core.sv
rtl/sparkle_permutation.sv
rtl/spk_checker.sv
verif/sparkle_permutation_tb.sv
